[src/unique_key_value_table_defines.svh]
// Assertion macros used by the checker of this block.
`ifndef UNIQUE_KEY_VALUE_TABLE_DEFINES_SVH
`define UNIQUE_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UKVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define UKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ukvt_pkg.sv]
package ukvt_pkg;

  // Operation codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_COUNT  = 3'd3,
    OP_CLEAR  = 3'd4
  } ukvt_op_e;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_FULL    = 2'd1;
  localparam logic [1:0] STATUS_MISSING = 2'd2;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_MOVE,
    ST_DONE
  } ukvt_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] lookup_key;
    logic [31:0] entry_value;
  } ukvt_in_t;

  typedef struct packed {
    logic        key_found;
    logic [31:0] read_value;
    logic [5:0]  match_count;
    logic [5:0]  entries_used;
    logic [1:0]  status;
  } ukvt_out_t;

endpackage

[src/unique_key_value_table.sv]
// Table of up to TABLE_DEPTH unique 32-bit keys with 32-bit values, held in two
// single-port-read synchronous RAMs. One operation is handled at a time: insert,
// remove, lookup and count scan the entries in use through the RAM read port, one
// entry per cycle; the search stops early at a matching key. Remove moves the last
// entry into the freed slot, which costs one extra RAM read and write. Results sit
// in an output register, so a new operation is taken while the previous result
// waits for out_ready_i. No clearing pass is needed after reset: only entries
// below the entry count are ever read.
module unique_key_value_table #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ukvt_pkg::ukvt_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ukvt_pkg::ukvt_out_t out_data_o
);
  import ukvt_pkg::*;

  logic      res_valid, res_ready;
  ukvt_out_t res_data;
  logic      out_valid_q, out_valid_d;
  ukvt_out_t out_q;

  ukvt_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data)
  );

  // Output register: refilled when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res_data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[src/ukvt_ram.sv]
module ukvt_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[src/ukvt_ctrl.sv]
module ukvt_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ukvt_pkg::ukvt_in_t  in_data_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output ukvt_pkg::ukvt_out_t res_data_o
);
  import ukvt_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] Full = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] One  = CW'(1);

  ukvt_state_e   state_q, state_d;
  ukvt_in_t      req_q, req_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] scan_idx_q, scan_idx_d;
  logic          pend_q, pend_d;
  logic [AW-1:0] pend_idx_q, pend_idx_d;
  logic          hit_q, hit_d;
  logic [AW-1:0] slot_q, slot_d;
  logic [31:0]   rd_val_q, rd_val_d;
  logic [CW-1:0] match_q, match_d;
  logic [1:0]    status_q, status_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   key_wdata, val_wdata, key_rdata, val_rdata;
  logic          issue, scan_end, ins_ok;
  logic [CW-1:0] last_idx;

  // Key and value stores
  ukvt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(32)) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (key_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (key_rdata)
  );

  ukvt_ram #(.DEPTH(TABLE_DEPTH), .WIDTH(32)) u_val_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (val_wdata),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (val_rdata)
  );

  // Scan bookkeeping
  assign issue    = (state_q == ST_SCAN) && (scan_idx_q != count_q) && !hit_q;
  assign scan_end = !pend_q && (hit_q || (scan_idx_q == count_q));
  assign ins_ok   = (req_q.opcode == OP_INSERT) && !hit_q && (count_q != Full);
  assign last_idx = count_q - One;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.opcode == OP_INSERT || in_data_i.opcode == OP_REMOVE ||
              in_data_i.opcode == OP_LOOKUP || in_data_i.opcode == OP_COUNT) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (req_q.opcode == OP_REMOVE && hit_q) begin
          state_d = ST_MOVE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MOVE: state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Handshake and memory controls
  always_comb begin
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_idx_q[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];
    key_wdata   = req_q.lookup_key;
    val_wdata   = req_q.entry_value;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_SCAN: rd_en = issue;
      ST_APPLY: begin
        // remove fetches the last entry; insert appends at the end
        rd_en   = (req_q.opcode == OP_REMOVE) && hit_q;
        rd_addr = last_idx[AW-1:0];
        wr_en   = ins_ok;
      end
      ST_MOVE: begin
        wr_en     = 1'b1;
        wr_addr   = slot_q;
        key_wdata = key_rdata;
        val_wdata = val_rdata;
      end
      ST_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  // Datapath registers next values
  always_comb begin
    req_d      = req_q;
    count_d    = count_q;
    scan_idx_d = scan_idx_q;
    pend_d     = 1'b0;
    pend_idx_d = scan_idx_q[AW-1:0];
    hit_d      = hit_q;
    slot_d     = slot_q;
    rd_val_d   = rd_val_q;
    match_d    = match_q;
    status_d   = status_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d      = in_data_i;
          scan_idx_d = '0;
          hit_d      = 1'b0;
          rd_val_d   = '0;
          match_d    = '0;
          status_d   = STATUS_OK;
          if (in_data_i.opcode == OP_CLEAR) begin
            count_d = '0;
          end
        end
      end
      ST_SCAN: begin
        pend_d = issue;
        if (issue) begin
          scan_idx_d = scan_idx_q + One;
        end
        // compare the entry read in the previous cycle
        if (pend_q && !hit_q) begin
          if (req_q.opcode == OP_COUNT) begin
            if (val_rdata == req_q.entry_value) begin
              match_d = match_q + One;
            end
          end else if (key_rdata == req_q.lookup_key) begin
            hit_d    = 1'b1;
            slot_d   = pend_idx_q;
            rd_val_d = val_rdata;
          end
        end
      end
      ST_APPLY: begin
        if (ins_ok) begin
          count_d = count_q + One;
        end
        if (req_q.opcode == OP_INSERT && !hit_q && count_q == Full) begin
          status_d = STATUS_FULL;
        end
        if (req_q.opcode == OP_LOOKUP && !hit_q) begin
          status_d = STATUS_MISSING;
        end
      end
      ST_MOVE: count_d = last_idx;
      default: ;
    endcase
  end

  // Result
  always_comb begin
    res_data_o.key_found    = hit_q;
    res_data_o.read_value   = (req_q.opcode == OP_LOOKUP) ? rd_val_q : 32'd0;
    res_data_o.match_count  = 6'(match_q);
    res_data_o.entries_used = 6'(count_q);
    res_data_o.status       = status_q;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      status_q <= STATUS_OK;
      match_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      status_q <= status_d;
      match_q  <= match_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    scan_idx_q <= scan_idx_d;
    pend_idx_q <= pend_idx_d;
    slot_q     <= slot_d;
    rd_val_q   <= rd_val_d;
  end

endmodule

[src/ukvt_checker.sv]
`include "unique_key_value_table_defines.svh"

module ukvt_checker #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input ukvt_pkg::ukvt_out_t out_data_o
);
  import ukvt_pkg::*;

  // A stalled result transfer keeps its payload
  `UKVT_ASSERT_NEXT(a_out_hold,
    out_valid_o && !out_ready_i,
    out_valid_o && $stable(out_data_o),
    "result changed while stalled")

  // A refused insert only happens on a full table
  `UKVT_ASSERT_NOW(a_full_refusal,
    out_valid_o && out_data_o.status == STATUS_FULL,
    !out_data_o.key_found && out_data_o.entries_used == 6'(TABLE_DEPTH),
    "full status with table not full")

  // A missing key reports no value and no matches
  `UKVT_ASSERT_NOW(a_missing_clean,
    out_valid_o && out_data_o.status == STATUS_MISSING,
    !out_data_o.key_found && out_data_o.read_value == 32'd0 && out_data_o.match_count == 6'd0,
    "missing key result not clean")

  // A found key never comes with an error status
  `UKVT_ASSERT_NOW(a_found_ok,
    out_valid_o && out_data_o.key_found,
    out_data_o.status == STATUS_OK,
    "found key with error status")

endmodule

bind unique_key_value_table ukvt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ukvt_checker (.*);

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ukvt_pkg::*;

  localparam int unsigned TABLE_DEPTH = 32;
  localparam int KEY_POOL_SIZE = 48;
  localparam int VALUE_POOL_SIZE = 6;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_GAP = 8;

  // Opcodes the block leaves unused
  localparam logic [2:0] OPC_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OPC_SPARE_LAST = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ukvt_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ukvt_out_t out_data_o;

  // Table as the testbench expects it
  logic [31:0] held_keys [TABLE_DEPTH];
  logic [31:0] held_values [TABLE_DEPTH];
  int entries_held = 0;

  ukvt_out_t expected_results [$];
  logic [31:0] key_pool [KEY_POOL_SIZE];
  logic [31:0] value_pool [VALUE_POOL_SIZE];

  bit failed = 1'b0;
  bit offering = 1'b0;
  bit no_idle = 1'b0;
  bit hold_request = 1'b0;
  int idle_cycles = 0;

  unique_key_value_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one operation to the expected table and returns its result
  function automatic ukvt_out_t apply_table_op(input ukvt_in_t cmd);
    ukvt_out_t res;
    int slot;
    int hits;
    res = '0;
    slot = -1;
    hits = 0;
    for (int i = 0; i < entries_held; i++) begin
      if (slot < 0 && held_keys[i] == cmd.lookup_key) slot = i;
    end
    case (cmd.opcode)
      OP_INSERT: begin
        if (slot >= 0) begin
          res.key_found = 1'b1;
        end else if (entries_held >= TABLE_DEPTH) begin
          res.status = STATUS_FULL;
        end else begin
          held_keys[entries_held] = cmd.lookup_key;
          held_values[entries_held] = cmd.entry_value;
          entries_held++;
        end
      end
      OP_REMOVE: begin
        if (slot >= 0) begin
          res.key_found = 1'b1;
          // last entry fills the hole
          held_keys[slot] = held_keys[entries_held - 1];
          held_values[slot] = held_values[entries_held - 1];
          entries_held--;
        end
      end
      OP_LOOKUP: begin
        if (slot >= 0) begin
          res.key_found = 1'b1;
          res.read_value = held_values[slot];
        end else begin
          res.status = STATUS_MISSING;
        end
      end
      OP_COUNT: begin
        for (int i = 0; i < entries_held; i++) begin
          if (held_values[i] == cmd.entry_value) hits++;
        end
      end
      OP_CLEAR: begin
        entries_held = 0;
      end
      default: ;
    endcase
    res.match_count = 6'(hits);
    res.entries_used = 6'(entries_held);
    return res;
  endfunction

  function automatic ukvt_in_t make_op(input logic [2:0] opc, input logic [31:0] key,
                                       input logic [31:0] val);
    ukvt_in_t cmd;
    cmd.opcode = opc;
    cmd.lookup_key = key;
    cmd.entry_value = val;
    return cmd;
  endfunction

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Offer one operation and wait for its transfer
  task automatic send_op(input ukvt_in_t cmd);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      if (offering) begin
        in_valid_i <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= cmd;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(apply_table_op(cmd));
  endtask

  task automatic release_input();
    if (offering) begin
      in_valid_i <= 1'b0;
      offering = 1'b0;
    end
  endtask

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    if (r < 80) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 70) return value_pool[$urandom_range(0, VALUE_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  // Empty table edge cases, extreme keys and values, every opcode
  task automatic test_directed_cases();
    send_op(make_op(OP_LOOKUP, 32'h0, 32'h0));
    send_op(make_op(OP_REMOVE, 32'h0, 32'h0));
    send_op(make_op(OP_COUNT, 32'h0, 32'h0));
    send_op(make_op(OP_INSERT, 32'h0, 32'hFFFF_FFFF));
    send_op(make_op(OP_INSERT, 32'hFFFF_FFFF, 32'h0));
    send_op(make_op(OP_INSERT, 32'h0, 32'h5));
    send_op(make_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(OP_LOOKUP, 32'h0, 32'h0));
    send_op(make_op(OP_COUNT, 32'h0, 32'h0));
    send_op(make_op(OP_COUNT, 32'h0, 32'hFFFF_FFFF));
    send_op(make_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0));
    send_op(make_op(OP_REMOVE, 32'hFFFF_FFFF, 32'h0));
    send_op(make_op(OP_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5));
    send_op(make_op(OP_REMOVE, 32'h0, 32'h0));
    send_op(make_op(OP_LOOKUP, 32'h0, 32'h0));
    send_op(make_op(OP_LOOKUP, 32'hA5A5_5A5A, 32'h0));
    for (logic [3:0] opc = 4'(OPC_SPARE_FIRST); opc <= 4'(OPC_SPARE_LAST); opc++) begin
      send_op(make_op(opc[2:0], 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    end
    send_op(make_op(OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_op(make_op(OP_LOOKUP, 32'hA5A5_5A5A, 32'h0));
    send_op(make_op(OP_COUNT, 32'h0, 32'h5A5A_A5A5));
  endtask

  // Fill to capacity, push past it, then take entries out at both ends
  task automatic test_fill_and_overflow();
    logic [31:0] fill_keys [TABLE_DEPTH];
    send_op(make_op(OP_CLEAR, $urandom, $urandom));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      // top bits of the key keep each one distinct
      fill_keys[i] = ($urandom & 32'h07FF_FFFF) | (32'(i) << 27);
      send_op(make_op(OP_INSERT, fill_keys[i], (i % 3 == 0) ? 32'hFFFF_FFFF : $urandom));
    end
    send_op(make_op(OP_INSERT, 32'hFFFF_FFFF, $urandom));
    send_op(make_op(OP_INSERT, fill_keys[7], $urandom));
    send_op(make_op(OP_LOOKUP, fill_keys[0], $urandom));
    send_op(make_op(OP_LOOKUP, fill_keys[TABLE_DEPTH - 1], $urandom));
    send_op(make_op(OP_COUNT, $urandom, 32'hFFFF_FFFF));
    send_op(make_op(OP_REMOVE, fill_keys[TABLE_DEPTH - 1], $urandom));
    send_op(make_op(OP_REMOVE, fill_keys[0], $urandom));
    send_op(make_op(OP_LOOKUP, fill_keys[TABLE_DEPTH - 2], $urandom));
    send_op(make_op(OP_INSERT, 32'hFFFF_FFFF, $urandom));
    send_op(make_op(OP_INSERT, 32'h0, $urandom));
    send_op(make_op(OP_INSERT, 32'h1, $urandom));
    send_op(make_op(OP_COUNT, $urandom, 32'hFFFF_FFFF));
    send_op(make_op(OP_CLEAR, $urandom, $urandom));
  endtask

  // Receiver stalls long while operations keep coming
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_op(make_op((i % 2 == 0) ? OP_INSERT : OP_LOOKUP, key_pool[i], value_pool[i % 2]));
    end
  endtask

  task automatic run_random_phase(input int n_items, input int insert_pct, input bit eager);
    int r;
    logic [2:0] opc;
    no_idle = eager;
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < VALUE_POOL_SIZE; i++) value_pool[i] = $urandom;
    for (int n = 0; n < n_items; n++) begin
      r = $urandom_range(0, 99);
      if (r < insert_pct) begin
        opc = OP_INSERT;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 30) opc = OP_REMOVE;
        else if (r < 70) opc = OP_LOOKUP;
        else if (r < 92) opc = OP_COUNT;
        else if (r < 95) opc = OP_CLEAR;
        else opc = 3'($urandom_range(OPC_SPARE_FIRST, OPC_SPARE_LAST));
      end
      send_op(make_op(opc, pick_key(), pick_value()));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(150, 60, 1'b0);
    run_random_phase(150, 40, 1'b0);
    run_random_phase(100, 70, 1'b1);
    run_random_phase(150, 30, 1'b0);
    run_random_phase(150, 55, 1'b0);
  endtask

  // Result side: random stalls, compare each transfer with the oldest prediction
  initial begin
    int stall;
    ukvt_out_t want;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (hold_request) begin
        stall = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      if (expected_results.size() == 0) begin
        $error("result transfer with nothing outstanding");
        failed = 1'b1;
      end else begin
        want = expected_results.pop_front();
        if (out_data_o.key_found !== want.key_found) begin
          $error("key_found: expected %0d, got %0d", want.key_found, out_data_o.key_found);
          failed = 1'b1;
        end
        if (out_data_o.read_value !== want.read_value) begin
          $error("read_value: expected %08h, got %08h", want.read_value, out_data_o.read_value);
          failed = 1'b1;
        end
        if (out_data_o.match_count !== want.match_count) begin
          $error("match_count: expected %0d, got %0d", want.match_count,
                 out_data_o.match_count);
          failed = 1'b1;
        end
        if (out_data_o.entries_used !== want.entries_used) begin
          $error("entries_used: expected %0d, got %0d", want.entries_used,
                 out_data_o.entries_used);
          failed = 1'b1;
        end
        if (out_data_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data_o.status);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    for (int i = 0; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    for (int i = 0; i < VALUE_POOL_SIZE; i++) value_pool[i] = $urandom;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_fill_and_overflow();
    test_output_backpressure();
    test_random_traffic();

    release_input();
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
